### rtl/core/scc_pkg.sv
// shared types, constants and the corner table of the solid column culler
package scc_pkg;

  localparam int SCREEN_COLUMNS_DEF = 320;
  localparam int COL_W = 9;
  localparam logic signed [31:0] NEAR_DEPTH = 32'sd524288;
  localparam logic signed [31:0] FX_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_BOX   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COS = 3'd3;

  // box region of the viewer that holds the viewer itself
  localparam logic [3:0] POS_INSIDE = 4'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_DELTA, OP_DIVGO, OP_DIVWB,
    OP_SPAN, OP_MASK, OP_SCAN, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    MS_SIN_DX1, MS_COS_DY1, MS_COS_DX1, MS_SIN_DY1,
    MS_SIN_DX2, MS_COS_DY2, MS_COS_DX2, MS_SIN_DY2,
    MS_CROSS_A, MS_CROSS_B, MS_CLIP_W1, MS_CLIP_W2, MS_CLIP_B1, MS_CLIP_B2
  } mul_sel_t;

  typedef enum logic [2:0] {
    DS_CLIP_W1, DS_CLIP_W2, DS_CLIP_B1, DS_CLIP_B2, DS_PROJ1, DS_PROJ2
  } div_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO, RES_VIS, RES_SPAN
  } res_t;

  typedef struct packed {
    dp_op_t   op;
    logic     mul_en;
    mul_sel_t mul_sel;
    div_sel_t div_sel;
    res_t     res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pos_inside;
    logic       cone_rej;
    logic       near_rej;
    logic       cross_le0;
    logic       cross_lt2;
    logic       behind;
    logic       y1_near;
    logic       y2_near;
    logic       x1_left;
    logic       x2_right;
    logic       div_done;
  } sts_t;

  // corner indexes {x1, y1, x2, y2} into {top, bottom, left, right}
  function automatic logic [7:0] corner_pick(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = {2'd3, 2'd0, 2'd2, 2'd1};
      4'd1:    r = {2'd3, 2'd0, 2'd2, 2'd0};
      4'd2:    r = {2'd3, 2'd1, 2'd2, 2'd0};
      4'd4:    r = {2'd2, 2'd0, 2'd2, 2'd1};
      4'd6:    r = {2'd3, 2'd1, 2'd3, 2'd0};
      4'd8:    r = {2'd2, 2'd0, 2'd3, 2'd1};
      4'd9:    r = {2'd2, 2'd1, 2'd3, 2'd1};
      4'd10:   r = {2'd2, 2'd1, 2'd3, 2'd0};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/scc_div.sv
// restoring 16.16 fixed-point divider, one quotient bit per cycle, saturating
module scc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q
);
  import scc_pkg::*;

  logic        run_r, fin_r, done_r, neg_r;
  logic [5:0]  cnt_r;
  logic [47:0] nq_r;
  logic [31:0] rem_r, den_r;
  logic signed [31:0] q_r;
  logic [32:0] sh, diff;
  logic [31:0] mag_a, mag_b;

  assign mag_a = a[31] ? 32'd0 - a : a;
  assign mag_b = b[31] ? 32'd0 - b : b;
  assign sh    = {rem_r, nq_r[47]};
  assign diff  = sh - {1'b0, den_r};

  // iteration and final saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (b == 32'sd0) begin
          q_r    <= a[31] ? FX_MIN : FX_MAX;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          cnt_r <= 6'd0;
          nq_r  <= {mag_a, 16'd0};
          rem_r <= 32'd0;
          den_r <= mag_b;
          neg_r <= a[31] ^ b[31];
        end
      end else if (run_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          nq_r  <= {nq_r[46:0], 1'b1};
        end else begin
          rem_r <= sh[31:0];
          nq_r  <= {nq_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (neg_r) begin
          q_r <= (nq_r > 48'h80000000) ? FX_MIN : 32'd0 - nq_r[31:0];
        end else begin
          q_r <= (nq_r > 48'h7FFFFFFF) ? FX_MAX : nq_r[31:0];
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

### rtl/core/scc_dpath.sv
// datapath: view registers, rotation, clipping, projection and the solid map
module scc_dpath #(
  parameter int SCREEN_COLUMNS = scc_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scc_pkg::cmd_t                  cmd,
  output scc_pkg::sts_t                  sts,
  input  logic                           cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [1:0]                     in_kind,
  input  logic signed [31:0]             in_coord_a,
  input  logic signed [31:0]             in_coord_b,
  input  logic signed [31:0]             in_coord_c,
  input  logic signed [31:0]             in_coord_d,
  input  logic                           in_never_occludes,
  input  logic                           in_has_back_sector,
  input  logic signed [31:0]             in_front_floor,
  input  logic signed [31:0]             in_front_ceiling,
  input  logic signed [31:0]             in_back_floor,
  input  logic signed [31:0]             in_back_ceiling,
  input  logic                           in_sky_ceiling,
  output logic                           out_strobe,
  output logic                           out_visible,
  output logic [scc_pkg::COL_W-1:0]      out_span_start,
  output logic [scc_pkg::COL_W-1:0]      out_span_end,
  output logic                           out_sky_seen,
  output logic                           out_made_solid
);
  import scc_pkg::*;

  localparam logic signed [31:0] COLS_S = 32'(SCREEN_COLUMNS);
  localparam logic signed [31:0] HALF_S = 32'(SCREEN_COLUMNS / 2);
  localparam logic [COL_W-1:0]   COLS_U = COL_W'(SCREEN_COLUMNS);

  // view registers
  logic signed [31:0] view_x_r, view_y_r;
  logic signed [17:0] sin_r, cos_r;
  // captured item
  logic [1:0]         kind_r;
  logic [3:0]         pos_r;
  logic signed [31:0] crd_r [4];
  logic               never_r, back_r, sky_r;
  logic signed [31:0] ff_r, fc_r, bf_r, bc_r;
  // working values
  logic signed [31:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [31:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [63:0] p_r;
  mul_sel_t           psel_r;
  logic               pv_r;
  logic signed [33:0] cr_r;
  logic signed [31:0] d_r, mdiff_r, s_r, e_r;
  logic [COL_W-1:0]   ss_r, ee_r;
  logic               ne_r, lt_r, open_r, made_r;
  logic [SCREEN_COLUMNS-1:0] mask_r, solid_r;
  // result registers
  logic               strobe_r, vis_r, skyo_r, madeo_r;
  logic [COL_W-1:0]   starto_r, endo_r;

  logic signed [31:0] sin32, cos32, ma, mb, fx, div_a, div_b, mdiff_nxt;
  logic signed [31:0] div_q, proj, sc, ec, ny1, ny2, fy1;
  logic [7:0]         pick;
  logic [1:0]         bx, by;
  logic               div_done, mark;

  assign sin32 = {{14{sin_r[17]}}, sin_r};
  assign cos32 = {{14{cos_r[17]}}, cos_r};
  assign fx    = p_r[47:16];
  assign ny1   = 32'sd0 - y1_r;
  assign ny2   = 32'sd0 - y2_r;
  assign fy1   = y1_r + fx;
  assign pick  = corner_pick(pos_r);
  assign proj  = (div_q >>> 9) + (div_q >>> 11) + HALF_S;

  // viewer region of a box, from the incoming edges
  always_comb begin
    if (view_x_r < in_coord_c) bx = 2'd0;
    else if (view_x_r <= in_coord_d) bx = 2'd1;
    else bx = 2'd2;
    if (view_y_r > in_coord_a) by = 2'd0;
    else if (view_y_r >= in_coord_b) by = 2'd1;
    else by = 2'd2;
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_SIN_DX1: begin ma = sin32; mb = dx1_r; end
      MS_COS_DY1: begin ma = cos32; mb = dy1_r; end
      MS_COS_DX1: begin ma = cos32; mb = dx1_r; end
      MS_SIN_DY1: begin ma = sin32; mb = dy1_r; end
      MS_SIN_DX2: begin ma = sin32; mb = dx2_r; end
      MS_COS_DY2: begin ma = cos32; mb = dy2_r; end
      MS_COS_DX2: begin ma = cos32; mb = dx2_r; end
      MS_SIN_DY2: begin ma = sin32; mb = dy2_r; end
      MS_CROSS_A: begin
        ma = {{16{x2_r[31]}}, x2_r[31:16]};
        mb = {{16{y1_r[31]}}, y1_r[31:16]};
      end
      MS_CROSS_B: begin
        ma = {{16{x1_r[31]}}, x1_r[31:16]};
        mb = {{16{y2_r[31]}}, y2_r[31:16]};
      end
      default: begin ma = d_r; mb = mdiff_r; end
    endcase
  end

  // divider operands and clip slope difference
  always_comb begin
    div_a     = x1_r;
    div_b     = y1_r;
    mdiff_nxt = y2_r - y1_r;
    case (cmd.div_sel)
      DS_CLIP_W1: begin
        div_a = NEAR_DEPTH - y1_r; div_b = y2_r - y1_r; mdiff_nxt = x2_r - x1_r;
      end
      DS_CLIP_W2: begin
        div_a = NEAR_DEPTH - y2_r; div_b = y1_r - y2_r; mdiff_nxt = x1_r - x2_r;
      end
      DS_CLIP_B1: begin
        div_a = x1_r + y1_r; div_b = x1_r + y1_r - x2_r - y2_r;
      end
      DS_CLIP_B2: begin
        div_a = x1_r - y1_r; div_b = x1_r - y1_r - x2_r + y2_r;
      end
      DS_PROJ1: begin div_a = x1_r; div_b = y1_r; end
      DS_PROJ2: begin div_a = x2_r; div_b = y2_r; end
      default: begin div_a = x1_r; div_b = y1_r; end
    endcase
  end

  scc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIVGO),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  // span clamping
  assign sc   = s_r[31] ? 32'sd0 : s_r;
  assign ec   = (e_r > COLS_S) ? COLS_S : e_r;
  assign mark = (kind_r == KIND_WALL) && !never_r && lt_r &&
                (!back_r || bc_r <= ff_r || bf_r >= fc_r || bf_r == bc_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= 32'sd0;
      view_y_r <= 32'sd0;
      sin_r    <= 18'sd0;
      cos_r    <= 18'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_X:   view_x_r <= cfg_data;
        CFG_VIEW_Y:   view_y_r <= cfg_data;
        CFG_VIEW_SIN: sin_r    <= cfg_data[17:0];
        CFG_VIEW_COS: cos_r    <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_en;
    end
    p_r    <= ma * mb;
    psel_r <= cmd.mul_sel;
  end

  // working registers and the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r <= '0;
    end else begin
      // product write-back
      if (pv_r) begin
        case (psel_r)
          MS_SIN_DX1: x1_r <= fx;
          MS_COS_DY1: x1_r <= x1_r - fx;
          MS_COS_DX1: y1_r <= fx;
          MS_SIN_DY1: y1_r <= y1_r + fx;
          MS_SIN_DX2: x2_r <= fx;
          MS_COS_DY2: x2_r <= x2_r - fx;
          MS_COS_DX2: y2_r <= fx;
          MS_SIN_DY2: y2_r <= y2_r + fx;
          MS_CROSS_A: cr_r <= p_r[33:0];
          MS_CROSS_B: cr_r <= cr_r - p_r[33:0];
          MS_CLIP_W1: begin x1_r <= x1_r + fx; y1_r <= NEAR_DEPTH; end
          MS_CLIP_W2: begin x2_r <= x2_r + fx; y2_r <= NEAR_DEPTH; end
          MS_CLIP_B1: begin y1_r <= fy1; x1_r <= 32'sd0 - fy1; end
          MS_CLIP_B2: begin x2_r <= fy1; y2_r <= fy1; end
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          kind_r   <= in_kind;
          pos_r    <= {by, bx};
          crd_r[0] <= in_coord_a;
          crd_r[1] <= in_coord_b;
          crd_r[2] <= in_coord_c;
          crd_r[3] <= in_coord_d;
          never_r  <= in_never_occludes;
          back_r   <= in_has_back_sector;
          sky_r    <= in_sky_ceiling;
          ff_r     <= in_front_floor;
          fc_r     <= in_front_ceiling;
          bf_r     <= in_back_floor;
          bc_r     <= in_back_ceiling;
        end
        OP_CLEAR: solid_r <= '0;
        OP_DELTA: begin
          if (kind_r == KIND_WALL) begin
            dx1_r <= crd_r[0] - view_x_r;
            dy1_r <= crd_r[1] - view_y_r;
            dx2_r <= crd_r[2] - view_x_r;
            dy2_r <= crd_r[3] - view_y_r;
          end else begin
            dx1_r <= crd_r[pick[7:6]] - view_x_r;
            dy1_r <= crd_r[pick[5:4]] - view_y_r;
            dx2_r <= crd_r[pick[3:2]] - view_x_r;
            dy2_r <= crd_r[pick[1:0]] - view_y_r;
          end
        end
        OP_DIVGO: mdiff_r <= mdiff_nxt;
        OP_DIVWB: begin
          case (cmd.div_sel)
            DS_PROJ1: s_r <= proj;
            DS_PROJ2: e_r <= proj;
            default:  d_r <= div_q;
          endcase
        end
        OP_SPAN: begin
          ss_r <= (sc > COLS_S) ? COLS_U : sc[COL_W-1:0];
          ee_r <= ec[31] ? '0 : ec[COL_W-1:0];
          ne_r <= sc != ec;
          lt_r <= sc < ec;
        end
        OP_MASK: begin
          for (int i = 0; i < SCREEN_COLUMNS; i++) begin
            mask_r[i] <= (COL_W'(i) >= ss_r) && (COL_W'(i) < ee_r);
          end
        end
        OP_SCAN: begin
          open_r <= |(mask_r & ~solid_r);
          made_r <= mark;
          if (mark) solid_r <= solid_r | mask_r;
        end
        default: ;
      endcase
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == OP_OUT);
    end
    if (cmd.op == OP_OUT) begin
      case (cmd.res)
        RES_SPAN: begin
          vis_r    <= open_r;
          starto_r <= ss_r;
          endo_r   <= ee_r;
          skyo_r   <= (kind_r == KIND_WALL) && ne_r && sky_r;
          madeo_r  <= made_r;
        end
        RES_VIS: begin
          vis_r <= 1'b1; starto_r <= '0; endo_r <= '0; skyo_r <= 1'b0; madeo_r <= 1'b0;
        end
        default: begin
          vis_r <= 1'b0; starto_r <= '0; endo_r <= '0; skyo_r <= 1'b0; madeo_r <= 1'b0;
        end
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    sts.kind       = kind_r;
    sts.pos_inside = pos_r == POS_INSIDE;
    sts.x1_left    = x1_r < ny1;
    sts.x2_right   = y2_r < x2_r;
    sts.cone_rej   = (sts.x1_left && x2_r < ny2) || (y1_r < x1_r && y2_r < x2_r);
    sts.near_rej   = (y1_r < NEAR_DEPTH + 32'sd1) && (y2_r < NEAR_DEPTH + 32'sd1);
    sts.cross_le0  = cr_r <= 34'sd0;
    sts.cross_lt2  = cr_r < 34'sd2;
    sts.behind     = (y1_r <= 32'sd0) && (y2_r <= 32'sd0);
    sts.y1_near    = y1_r < NEAR_DEPTH;
    sts.y2_near    = y2_r < NEAR_DEPTH;
    sts.div_done   = div_done;
  end

  assign out_strobe     = strobe_r;
  assign out_visible    = vis_r;
  assign out_span_start = starto_r;
  assign out_span_end   = endo_r;
  assign out_sky_seen   = skyo_r;
  assign out_made_solid = madeo_r;

endmodule

### rtl/core/scc_ctrl.sv
// controller: sequences load, rotation, tests, divisions, scan and result
module scc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output scc_pkg::cmd_t cmd,
  input  scc_pkg::sts_t sts
);
  import scc_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_DELTA   = 17'b00000000000000010,
    S_ROT     = 17'b00000000000000100,
    S_RWAIT   = 17'b00000000000001000,
    S_TEST1   = 17'b00000000000010000,
    S_CROSS   = 17'b00000000000100000,
    S_CWAIT   = 17'b00000000001000000,
    S_TEST2   = 17'b00000000010000000,
    S_DIVGO   = 17'b00000000100000000,
    S_DIVRUN  = 17'b00000001000000000,
    S_CLIPMUL = 17'b00000010000000000,
    S_CLIPWT  = 17'b00000100000000000,
    S_CLIPCHK = 17'b00001000000000000,
    S_SPAN    = 17'b00010000000000000,
    S_MASK    = 17'b00100000000000000,
    S_SCAN    = 17'b01000000000000000,
    S_OUT     = 17'b10000000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  div_sel_t   dsel_r, dsel_nxt;
  res_t       res_r, res_nxt;
  logic       wall;

  assign wall = sts.kind == KIND_WALL;
  assign busy = state_r != S_IDLE;

  // next state and command
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dsel_nxt    = dsel_r;
    res_nxt     = res_r;
    cmd.op      = OP_NONE;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = MS_SIN_DX1;
    cmd.div_sel = dsel_r;
    cmd.res     = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        res_nxt = RES_ZERO;
        if (sts.kind == KIND_CLEAR) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_OUT;
        end else if (sts.kind == KIND_BOX && sts.pos_inside) begin
          res_nxt   = RES_VIS;
          state_nxt = S_OUT;
        end else if (sts.kind == KIND_WALL || sts.kind == KIND_BOX) begin
          cmd.op    = OP_DELTA;
          step_nxt  = 3'd0;
          state_nxt = S_ROT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ROT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mul_sel_t'({1'b0, step_r});
        step_nxt    = step_r + 3'd1;
        if (step_r == 3'd7) state_nxt = S_RWAIT;
      end
      S_RWAIT: state_nxt = S_TEST1;
      S_TEST1: begin
        step_nxt = 3'd0;
        if (sts.cone_rej || (wall && sts.near_rej)) state_nxt = S_OUT;
        else state_nxt = S_CROSS;
      end
      S_CROSS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = step_r[0] ? MS_CROSS_B : MS_CROSS_A;
        step_nxt    = step_r + 3'd1;
        if (step_r[0]) state_nxt = S_CWAIT;
      end
      S_CWAIT: state_nxt = S_TEST2;
      S_TEST2: begin
        state_nxt = S_DIVGO;
        dsel_nxt  = DS_PROJ1;
        if (wall) begin
          if (sts.cross_le0) state_nxt = S_OUT;
          else if (sts.y1_near) dsel_nxt = DS_CLIP_W1;
          else if (sts.y2_near) dsel_nxt = DS_CLIP_W2;
        end else begin
          if (sts.cross_lt2) begin
            res_nxt   = RES_VIS;
            state_nxt = S_OUT;
          end else if (sts.behind) state_nxt = S_OUT;
          else if (sts.x1_left) dsel_nxt = DS_CLIP_B1;
          else if (sts.x2_right) dsel_nxt = DS_CLIP_B2;
        end
      end
      S_DIVGO: begin
        cmd.op    = OP_DIVGO;
        state_nxt = S_DIVRUN;
      end
      S_DIVRUN: begin
        if (sts.div_done) begin
          cmd.op = OP_DIVWB;
          case (dsel_r)
            DS_PROJ1: begin
              dsel_nxt  = DS_PROJ2;
              state_nxt = S_DIVGO;
            end
            DS_PROJ2: state_nxt = S_SPAN;
            default:  state_nxt = S_CLIPMUL;
          endcase
        end
      end
      S_CLIPMUL: begin
        cmd.mul_en = 1'b1;
        case (dsel_r)
          DS_CLIP_W1: cmd.mul_sel = MS_CLIP_W1;
          DS_CLIP_W2: cmd.mul_sel = MS_CLIP_W2;
          DS_CLIP_B1: cmd.mul_sel = MS_CLIP_B1;
          default:    cmd.mul_sel = MS_CLIP_B2;
        endcase
        state_nxt = S_CLIPWT;
      end
      S_CLIPWT: state_nxt = S_CLIPCHK;
      S_CLIPCHK: begin
        state_nxt = S_DIVGO;
        if (dsel_r == DS_CLIP_B1 && sts.x2_right) dsel_nxt = DS_CLIP_B2;
        else dsel_nxt = DS_PROJ1;
      end
      S_SPAN: begin
        cmd.op    = OP_SPAN;
        state_nxt = S_MASK;
      end
      S_MASK: begin
        cmd.op    = OP_MASK;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op    = OP_SCAN;
        res_nxt   = RES_SPAN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op    = OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 3'd0;
      dsel_r  <= DS_PROJ1;
      res_r   <= RES_ZERO;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dsel_r  <= dsel_nxt;
      res_r   <= res_nxt;
    end
  end

  // the divider only finishes while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIVRUN)
    else $error("divider finished outside its wait state");

  // an accepted item always leads to dispatch
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_DELTA)
    else $error("accepted item not dispatched");

  // a result is issued once and the block returns idle
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> (state_r == S_IDLE && cmd.op != OP_OUT))
    else $error("result issued twice");

endmodule

### rtl/core/solid_column_occlusion_culler.sv
// top level of the solid column occlusion culler
// a frame start (clear) or a trivial item goes straight to the result; rejected items
// stop after the tests, and a projected wall or box runs the bit-serial divider once
// to project each end and once per clip.
// one item at a time: busy is high until the result is issued.
// synchronous active-low reset opens every column and loads the reset view.
module solid_column_occlusion_culler #(
  parameter int SCREEN_COLUMNS = scc_pkg::SCREEN_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [1:0]                     in_kind,
  input  logic signed [31:0]             in_coord_a,
  input  logic signed [31:0]             in_coord_b,
  input  logic signed [31:0]             in_coord_c,
  input  logic signed [31:0]             in_coord_d,
  input  logic                           in_never_occludes,
  input  logic                           in_has_back_sector,
  input  logic signed [31:0]             in_front_floor,
  input  logic signed [31:0]             in_front_ceiling,
  input  logic signed [31:0]             in_back_floor,
  input  logic signed [31:0]             in_back_ceiling,
  input  logic                           in_sky_ceiling,
  output logic                           out_strobe,
  output logic                           out_visible,
  output logic [scc_pkg::COL_W-1:0]      out_span_start,
  output logic [scc_pkg::COL_W-1:0]      out_span_end,
  output logic                           out_sky_seen,
  output logic                           out_made_solid
);
  import scc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  scc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // arithmetic and column map
  scc_dpath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_coord_a         (in_coord_a),
    .in_coord_b         (in_coord_b),
    .in_coord_c         (in_coord_c),
    .in_coord_d         (in_coord_d),
    .in_never_occludes  (in_never_occludes),
    .in_has_back_sector (in_has_back_sector),
    .in_front_floor     (in_front_floor),
    .in_front_ceiling   (in_front_ceiling),
    .in_back_floor      (in_back_floor),
    .in_back_ceiling    (in_back_ceiling),
    .in_sky_ceiling     (in_sky_ceiling),
    .out_strobe         (out_strobe),
    .out_visible        (out_visible),
    .out_span_start     (out_span_start),
    .out_span_end       (out_span_end),
    .out_sky_seen       (out_sky_seen),
    .out_made_solid     (out_made_solid)
  );

endmodule
